@@ design/bcbe_pkg.sv @@
// Shared types and constants for the battery current budget estimator.
package bcbe_pkg;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_CAPACITY  = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_ALPHA     = 3'd2,
        REG_INV_MAX   = 3'd3,
        REG_TARGET    = 3'd4
    } bcbe_reg_addr_t;

    // Register reset values
    localparam logic [23:0] CAPACITY_RESET  = 24'd100000;
    localparam logic [16:0] THRESHOLD_RESET = 17'd0;
    localparam logic [16:0] ALPHA_RESET     = 17'd6554;
    localparam logic [15:0] INV_MAX_RESET   = 16'd15000;
    localparam logic [15:0] TARGET_RESET    = 16'd100;

    // Arithmetic constants
    localparam logic [16:0] Q16_ONE        = 17'd65536;
    localparam logic [13:0] SOC_FULL       = 14'd10000;
    localparam logic [15:0] SOC_DIVISOR    = 16'd10000;
    localparam logic [15:0] SOC_ROUND      = 16'd5000;
    localparam logic [15:0] RUNTIME_IDLE   = 16'd9990;
    localparam logic [15:0] RUNTIME_MAX    = 16'hFFFF;
    localparam logic [15:0] DEFAULT_TARGET = 16'd100;
    localparam logic [16:0] SCALE_100      = 17'd100;

    // Serial arithmetic units
    localparam int unsigned MUL_ACC_W  = 48;
    localparam int unsigned MUL_BITS_W = 17;
    localparam int unsigned DIV_NUM_W  = 32;
    localparam int unsigned DIV_DEN_W  = 16;
    localparam int unsigned DIV_CNT_W  = 5;

    localparam logic [MUL_ACC_W-1:0] ROUND_HALF = 48'd32768;

    typedef struct packed {
        logic        busy;
        logic        done;
    } bcbe_unit_stat_t;

    typedef struct packed {
        logic [13:0] soc_percent_x100;
        logic [15:0] solar_current_ma;
        logic [15:0] forced_load_ma;
        logic [15:0] total_load_ma;
    } bcbe_in_t;

    typedef struct packed {
        logic [15:0] available_current_ma;
        logic [15:0] runtime_centihours;
        logic        not_draining;
        logic        runtime_saturated;
    } bcbe_out_t;

endpackage

@@ design/battery_current_budget_estimator.sv @@
// Battery current budget estimator: register port, sequencer and result register.
// Each input word takes two or three passes of the serial divider and four multiplier passes,
// plus any wait for the output register to empty, before its result word is registered.
// One word is worked on at a time; the block is ready for the next word once each result is
// registered, even while that result still waits. Synchronous active-low reset loads the
// register defaults and clears the filtered charge.
module battery_current_budget_estimator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bcbe_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bcbe_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bcbe_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  bcbe_pkg::bcbe_in_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output bcbe_pkg::bcbe_out_t                m_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_MIX_NEW,
        ST_MIX_OLD,
        ST_USABLE,
        ST_CHARGE,
        ST_SCALE,
        ST_RATE,
        ST_RUNTIME,
        ST_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [23:0]          cap_reg, cap_next;
    logic [16:0]          thr_reg, thr_next;
    logic [16:0]          alpha_reg, alpha_next;
    logic [15:0]          inv_reg, inv_next;
    logic [15:0]          target_reg, target_next;
    logic [16:0]          filt_reg, filt_next;
    bcbe_pkg::bcbe_in_t   in_reg, in_next;
    logic                 y_zero_reg, y_zero_next;
    logic [31:0]          z_hi_reg, z_hi_next;
    logic [15:0]          rate_reg, rate_next;
    logic [15:0]          runtime_reg, runtime_next;
    logic                 nd_reg, nd_next;
    logic                 sat_reg, sat_next;
    logic                 m_valid_reg, m_valid_next;
    bcbe_pkg::bcbe_out_t  m_data_reg, m_data_next;

    logic                                 mul_start;
    logic [bcbe_pkg::MUL_ACC_W-1:0]       mul_acc_init;
    logic [bcbe_pkg::MUL_ACC_W-1:0]       mul_mcand;
    logic [bcbe_pkg::MUL_BITS_W-1:0]      mul_mplier;
    logic [bcbe_pkg::MUL_ACC_W-1:0]       mul_product;
    bcbe_pkg::bcbe_unit_stat_t            mul_stat;
    logic                                 div_start;
    logic [bcbe_pkg::DIV_NUM_W-1:0]       div_num;
    logic [bcbe_pkg::DIV_DEN_W-1:0]       div_den;
    logic [bcbe_pkg::DIV_NUM_W-1:0]       div_quot;
    bcbe_pkg::bcbe_unit_stat_t            div_stat;

    logic [13:0]          soc_clamped;
    logic [16:0]          alpha_c;
    logic [16:0]          alpha_inv;
    logic [15:0]          target_eff;
    logic [17:0]          filt_diff;
    logic [16:0]          usable;
    logic [22:0]          solar_x100;
    logic [15:0]          drain_ma;
    logic [15:0]          avail;
    logic                 cfg_write;

    bcbe_serial_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_start),
        .acc_init (mul_acc_init),
        .mcand    (mul_mcand),
        .mplier   (mul_mplier),
        .product  (mul_product),
        .stat     (mul_stat)
    );

    bcbe_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .quot     (div_quot),
        .stat     (div_stat)
    );

    always_comb begin
        soc_clamped = (s_data.soc_percent_x100 > bcbe_pkg::SOC_FULL) ?
                      bcbe_pkg::SOC_FULL : s_data.soc_percent_x100;
        alpha_c     = (alpha_reg > bcbe_pkg::Q16_ONE) ? bcbe_pkg::Q16_ONE : alpha_reg;
        alpha_inv   = bcbe_pkg::Q16_ONE - alpha_c;
        target_eff  = (target_reg == '0) ? bcbe_pkg::DEFAULT_TARGET : target_reg;
        filt_diff   = {1'b0, filt_reg} - {1'b0, thr_reg};
        usable      = (filt_reg > thr_reg) ? filt_diff[16:0] : '0;
        solar_x100  = {1'b0, in_reg.solar_current_ma, 6'b0}
                    + {2'b0, in_reg.solar_current_ma, 5'b0}
                    + {5'b0, in_reg.solar_current_ma, 2'b0};
        drain_ma    = in_reg.total_load_ma - in_reg.solar_current_ma;
        avail       = (rate_reg > in_reg.forced_load_ma) ?
                      rate_reg - in_reg.forced_load_ma : '0;
        cfg_write   = psel && penable && pwrite;
    end

    // Register read-back
    always_comb begin
        case (paddr[4:2])
            bcbe_pkg::REG_CAPACITY:  prdata = {8'b0, cap_reg};
            bcbe_pkg::REG_THRESHOLD: prdata = {15'b0, thr_reg};
            bcbe_pkg::REG_ALPHA:     prdata = {15'b0, alpha_reg};
            bcbe_pkg::REG_INV_MAX:   prdata = {16'b0, inv_reg};
            bcbe_pkg::REG_TARGET:    prdata = {16'b0, target_reg};
            default:                 prdata = '0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cap_next     = cap_reg;
        thr_next     = thr_reg;
        alpha_next   = alpha_reg;
        inv_next     = inv_reg;
        target_next  = target_reg;
        filt_next    = filt_reg;
        in_next      = in_reg;
        y_zero_next  = y_zero_reg;
        z_hi_next    = z_hi_reg;
        rate_next    = rate_reg;
        runtime_next = runtime_reg;
        nd_next      = nd_reg;
        sat_next     = sat_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        mul_start    = 1'b0;
        mul_acc_init = '0;
        mul_mcand    = '0;
        mul_mplier   = '0;
        div_start    = 1'b0;
        div_num      = '0;
        div_den      = '0;

        if (cfg_write) begin
            case (paddr[4:2])
                bcbe_pkg::REG_CAPACITY:  cap_next    = pwdata[23:0];
                bcbe_pkg::REG_THRESHOLD: thr_next    = pwdata[16:0];
                bcbe_pkg::REG_ALPHA:     alpha_next  = pwdata[16:0];
                bcbe_pkg::REG_INV_MAX:   inv_next    = pwdata[15:0];
                bcbe_pkg::REG_TARGET:    target_next = pwdata[15:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next                  = s_data;
                    in_next.soc_percent_x100 = soc_clamped;
                    // The rounding term fits below the shifted charge, so it is appended.
                    div_start  = 1'b1;
                    div_num    = {2'b0, soc_clamped, bcbe_pkg::SOC_ROUND};
                    div_den    = bcbe_pkg::SOC_DIVISOR;
                    state_next = ST_SAMPLE;
                end
            end
            ST_SAMPLE: begin
                if (div_stat.done) begin
                    mul_start    = 1'b1;
                    mul_acc_init = bcbe_pkg::ROUND_HALF;
                    mul_mcand    = {31'b0, div_quot[16:0]};
                    mul_mplier   = alpha_c;
                    state_next   = ST_MIX_NEW;
                end
            end
            ST_MIX_NEW: begin
                if (mul_stat.done) begin
                    mul_start    = 1'b1;
                    mul_acc_init = mul_product;
                    mul_mcand    = {31'b0, filt_reg};
                    mul_mplier   = alpha_inv;
                    state_next   = ST_MIX_OLD;
                end
            end
            ST_MIX_OLD: begin
                if (mul_stat.done) begin
                    filt_next  = mul_product[32:16];
                    state_next = ST_USABLE;
                end
            end
            ST_USABLE: begin
                mul_start    = 1'b1;
                mul_acc_init = '0;
                mul_mcand    = {24'b0, cap_reg};
                mul_mplier   = usable;
                state_next   = ST_CHARGE;
            end
            ST_CHARGE: begin
                if (mul_stat.done) begin
                    y_zero_next  = (mul_product == '0);
                    mul_start    = 1'b1;
                    mul_acc_init = '0;
                    mul_mcand    = mul_product;
                    mul_mplier   = bcbe_pkg::SCALE_100;
                    state_next   = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (mul_stat.done) begin
                    // Dividing by target times 65536 is the same as dropping the low
                    // sixteen bits first; the solar term lands exactly on that boundary.
                    z_hi_next  = mul_product[47:16];
                    div_start  = 1'b1;
                    div_num    = mul_product[47:16] + {9'b0, solar_x100};
                    div_den    = target_eff;
                    state_next = ST_RATE;
                end
            end
            ST_RATE: begin
                if (div_stat.done) begin
                    rate_next = (div_quot > {16'b0, inv_reg}) ? inv_reg : div_quot[15:0];
                    sat_next  = 1'b0;
                    if (in_reg.total_load_ma <= in_reg.solar_current_ma) begin
                        runtime_next = bcbe_pkg::RUNTIME_IDLE;
                        nd_next      = 1'b1;
                        state_next   = ST_OUT;
                    end else if (y_zero_reg) begin
                        runtime_next = '0;
                        nd_next      = 1'b0;
                        state_next   = ST_OUT;
                    end else begin
                        nd_next    = 1'b0;
                        div_start  = 1'b1;
                        div_num    = z_hi_reg;
                        div_den    = drain_ma;
                        state_next = ST_RUNTIME;
                    end
                end
            end
            ST_RUNTIME: begin
                if (div_stat.done) begin
                    sat_next     = (div_quot[31:16] != '0);
                    runtime_next = (div_quot[31:16] != '0) ? bcbe_pkg::RUNTIME_MAX
                                                           : div_quot[15:0];
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.available_current_ma = avail;
                    m_data_next.runtime_centihours   = runtime_reg;
                    m_data_next.not_draining         = nd_reg;
                    m_data_next.runtime_saturated    = sat_reg;
                    m_valid_next                     = 1'b1;
                    state_next                       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= bcbe_pkg::CAPACITY_RESET;
            thr_reg     <= bcbe_pkg::THRESHOLD_RESET;
            alpha_reg   <= bcbe_pkg::ALPHA_RESET;
            inv_reg     <= bcbe_pkg::INV_MAX_RESET;
            target_reg  <= bcbe_pkg::TARGET_RESET;
            filt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            thr_reg     <= thr_next;
            alpha_reg   <= alpha_next;
            inv_reg     <= inv_next;
            target_reg  <= target_next;
            filt_reg    <= filt_next;
            m_valid_reg <= m_valid_next;
        end
        in_reg      <= in_next;
        y_zero_reg  <= y_zero_next;
        z_hi_reg    <= z_hi_next;
        rate_reg    <= rate_next;
        runtime_reg <= runtime_next;
        nd_reg      <= nd_next;
        sat_reg     <= sat_next;
        m_data_reg  <= m_data_next;
    end

    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The two arithmetic units are never in use at the same time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.busy |-> !div_stat.busy)
        else $error("multiplier and divider busy together");

    // Both units must have finished whenever a new word can be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!mul_stat.busy && !div_stat.busy))
        else $error("arithmetic unit still busy while idle");

    // The filtered charge is a weighted mean and never exceeds full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        filt_reg <= bcbe_pkg::Q16_ONE)
        else $error("filtered charge above full");

    // A word taken in keeps the block busy on the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while one is in progress");

    // A non-draining result carries the fixed runtime and no saturation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.not_draining) |->
        (m_data_reg.runtime_centihours == bcbe_pkg::RUNTIME_IDLE &&
         !m_data_reg.runtime_saturated))
        else $error("inconsistent non-draining result");

endmodule

@@ design/bcbe_serial_mul.sv @@
// Shift-and-add multiplier taking one multiplier bit per cycle, with a preloadable accumulator.
module bcbe_serial_mul (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [bcbe_pkg::MUL_ACC_W-1:0]        acc_init,
    input  logic [bcbe_pkg::MUL_ACC_W-1:0]        mcand,
    input  logic [bcbe_pkg::MUL_BITS_W-1:0]       mplier,
    output logic [bcbe_pkg::MUL_ACC_W-1:0]        product,
    output bcbe_pkg::bcbe_unit_stat_t             stat
);

    logic [bcbe_pkg::MUL_ACC_W-1:0]  acc_reg, acc_next;
    logic [bcbe_pkg::MUL_ACC_W-1:0]  mcand_reg, mcand_next;
    logic [bcbe_pkg::MUL_BITS_W-1:0] mplier_reg, mplier_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start) begin
            acc_next    = acc_init;
            mcand_next  = mcand;
            mplier_next = mplier;
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            // Stop as soon as no set multiplier bits remain.
            if (mplier_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[bcbe_pkg::MUL_ACC_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[bcbe_pkg::MUL_BITS_W-1:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ design/bcbe_serial_div.sv @@
// Restoring divider producing one quotient bit per cycle.
module bcbe_serial_div (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [bcbe_pkg::DIV_NUM_W-1:0]        num,
    input  logic [bcbe_pkg::DIV_DEN_W-1:0]        den,
    output logic [bcbe_pkg::DIV_NUM_W-1:0]        quot,
    output bcbe_pkg::bcbe_unit_stat_t             stat
);

    logic [bcbe_pkg::DIV_NUM_W-1:0] num_reg, num_next;
    logic [bcbe_pkg::DIV_DEN_W-1:0] den_reg, den_next;
    logic [bcbe_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [bcbe_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [bcbe_pkg::DIV_DEN_W:0]   rem_shift;
    logic [bcbe_pkg::DIV_DEN_W:0]   rem_diff;
    logic                           q_bit;

    always_comb begin
        rem_shift = {rem_reg, num_reg[bcbe_pkg::DIV_NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        q_bit     = (rem_shift >= {1'b0, den_reg});

        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            cnt_next  = '1;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // Quotient bits shift in behind the numerator as it leaves.
            num_next = {num_reg[bcbe_pkg::DIV_NUM_W-2:0], q_bit};
            rem_next = q_bit ? rem_diff[bcbe_pkg::DIV_DEN_W-1:0]
                             : rem_shift[bcbe_pkg::DIV_DEN_W-1:0];
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign quot      = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
